// ===== rtl/vs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_pkg: shared constants for the vector slerp pipeline
// Q30 angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package vs_pkg;

  localparam int CordicSteps = 30;

  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  localparam logic signed [33:0] HalfPi = 34'sd1686629714;
  localparam logic signed [33:0] PiQ30  = 34'sd3373259428;

  // atan(2^-idx) in Q30 radians, rounded to nearest
  function automatic logic signed [33:0] atan_q30(input int unsigned idx);
    logic signed [33:0] val;
    case (idx)
      0: val = 34'sd843314857;
      1: val = 34'sd497837829;
      2: val = 34'sd263043837;
      3: val = 34'sd133525159;
      4: val = 34'sd67021687;
      5: val = 34'sd33543516;
      6: val = 34'sd16775851;
      7: val = 34'sd8388437;
      8: val = 34'sd4194283;
      9: val = 34'sd2097149;
      default: val = 34'sd1 <<< (30 - idx);
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/vs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_in_if / vs_out_if: valid/ready channels of the vector slerp
// Input beat carries two vectors and the fraction, output beat the result.
// ----------------------------------------------------------------------------
interface vs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic [16:0]        frac;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, frac, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, frac, output ready);
endinterface

interface vs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               degenerate;

  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink   (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// ===== rtl/vs_sin.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_sin: pipelined rotation CORDIC
// Gained sine of a Q30 angle folded into [0, pi/2]; one step per stage.
// ----------------------------------------------------------------------------
module vs_sin (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] theta_i,
  output logic signed [33:0] sin_o
);
  import vs_pkg::*;

  logic signed [33:0] x_q [CordicSteps+1];
  logic signed [33:0] y_q [CordicSteps+1];
  logic signed [33:0] t_q [CordicSteps+1];
  logic signed [33:0] th_fold;

  always_comb begin
    th_fold = theta_i;
    if (th_fold < 0) th_fold = '0;
    if (th_fold > PiQ30) th_fold = PiQ30;
    if (th_fold > HalfPi) th_fold = PiQ30 - th_fold;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= OneQ30;
      y_q[0] <= '0;
      t_q[0] <= th_fold;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [33:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          t_q[i+1] <= t_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          t_q[i+1] <= t_q[i] + atan_q30(i);
        end
      end
    end
  end

  assign sin_o = y_q[CordicSteps];

endmodule

// ===== rtl/vs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_div: pipelined restoring divider for the slerp weights
// Q30 quotient num/den, one quotient bit per stage, saturated to +-2^46.
// ----------------------------------------------------------------------------
module vs_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] num_i,
  input  logic signed [33:0] den_i,
  output logic signed [47:0] w_o
);
  localparam int QBits = 48;
  localparam logic [47:0] Limit = 48'd1 << 46;

  logic [33:0] rem_q [QBits+1];
  logic [47:0] nl_q  [QBits+1];
  logic [47:0] q_q   [QBits+1];
  logic [33:0] den_q [QBits+1];
  logic        neg_q [QBits+1];
  logic        ovf_q [QBits+1];

  logic [33:0] mag;
  logic [63:0] nn;
  logic [47:0] qsat;

  assign mag = num_i[33] ? 34'(-num_i) : 34'(num_i);
  assign nn  = {mag, 30'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= 34'(nn[63:48]);
      nl_q[0]  <= nn[47:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[33];
      ovf_q[0] <= 34'(nn[63:48]) >= 34'(den_i);
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_step
    logic [33:0] r2;
    logic        take;
    assign r2   = {rem_q[k][32:0], nl_q[k][47]};
    assign take = r2 >= den_q[k];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? r2 - den_q[k] : r2;
        nl_q[k+1]  <= {nl_q[k][46:0], 1'b0};
        q_q[k+1]   <= {q_q[k][46:0], take};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign qsat = (ovf_q[QBits] || q_q[QBits] > Limit) ? Limit : q_q[QBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= neg_q[QBits] ? -signed'(qsat) : signed'(qsat);
    end
  end

endmodule

// ===== rtl/vector_slerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_slerp: spherical linear interpolation of two unit 3-vectors
// Deep pipeline: dot product, square root, arccosine CORDIC, three sine
// CORDICs, two weight dividers, weighted sum with rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_s carries a_x..b_z (Q2.14 style, FRACTION_BITS fraction bits) and
//   frac (t, Q1.16, clamped to 1). out_m returns out_x..out_z and the
//   degenerate flag, one result beat per input beat, in order.
//   Most stages are one step of a square root, CORDIC or divider and the
//   pipeline is fully unrolled, so a new beat is taken every cycle while
//   out_m is not stalled.
//   When out_m holds a result that is not taken, the whole pipeline holds
//   and in_s.ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; the payload registers are not reset.
//   Equal or opposite vectors give degenerate = 1 and out = a.
// ----------------------------------------------------------------------------
module vector_slerp #(
  parameter int FRACTION_BITS = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vs_in_if.sink    in_s,
  vs_out_if.source out_m
);
  import vs_pkg::*;

  localparam int Depth     = 151;
  localparam int IdxD      = 2;
  localparam int IdxVec0   = 36;
  localparam int IdxU      = 67;
  localparam int IdxDiv0   = 99;
  localparam int IdxMul    = 149;
  localparam int SqSteps   = 31;
  localparam int ShR       = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
  localparam int ShL       = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic [16:0]        f;
    logic signed [31:0] d;
    logic               degen;
  } side_t;

  logic             en;
  logic [Depth-1:0] vld_q;
  side_t            side_q [Depth];
  side_t            side_d [Depth];

  assign en         = !vld_q[Depth-1] || out_m.ready;
  assign in_s.ready = en;
  assign out_m.valid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_s.valid};
    end
  end

  // dot product and clamp
  logic signed [31:0] prod_q [3];
  logic signed [33:0] dot;
  logic signed [63:0] dsh;
  logic signed [31:0] d_w;

  assign dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]);
  always_comb begin
    dsh = (64'(dot) >>> ShR) <<< ShL;
    if (dsh > 64'(OneQ30)) d_w = 32'(OneQ30);
    else if (dsh < -64'(OneQ30)) d_w = -32'(OneQ30);
    else d_w = dsh[31:0];
  end

  // sine of omega: sqrt(1 - d^2)
  logic [60:0]        dd_q;
  logic signed [63:0] dd_w;
  logic [61:0]        sq_v_q [SqSteps+1];
  logic [61:0]        sq_r_q [SqSteps+1];

  assign dd_w = 64'(side_q[IdxD].d) * 64'(side_q[IdxD].d);

  // vectoring CORDIC state
  logic signed [33:0] vx_q [CordicSteps+1];
  logic signed [33:0] vy_q [CordicSteps+1];
  logic signed [33:0] vz_q [CordicSteps+1];
  logic signed [33:0] s_w, dv_w;

  assign s_w  = signed'({3'b0, sq_r_q[SqSteps][30:0]});
  assign dv_w = 34'(side_q[IdxVec0-1].d);

  // angle split
  logic signed [33:0] om_q, ua_q, ub_q;
  logic [48:0]        pua, pub;
  logic [31:0]        om_u;

  assign om_u = vz_q[CordicSteps][31:0];
  assign pua  = 49'(om_u) * 49'(17'd65536 - side_q[IdxU-1].f);
  assign pub  = 49'(om_u) * 49'(side_q[IdxU-1].f);

  logic signed [33:0] den_w, na_w, nb_w;
  logic signed [47:0] wa_w, wb_w;

  always_comb begin
    side_d[0].ax    = in_s.a_x;
    side_d[0].ay    = in_s.a_y;
    side_d[0].az    = in_s.a_z;
    side_d[0].bx    = in_s.b_x;
    side_d[0].by    = in_s.b_y;
    side_d[0].bz    = in_s.b_z;
    side_d[0].f     = (in_s.frac > 17'd65536) ? 17'd65536 : in_s.frac;
    side_d[0].d     = '0;
    side_d[0].degen = 1'b0;
    for (int k = 1; k < Depth; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[IdxD].d        = d_w;
    side_d[IdxVec0].degen = (sq_r_q[SqSteps] == '0);
    side_d[IdxDiv0].degen = side_q[IdxDiv0-1].degen | (den_w <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < Depth; k++) begin
        side_q[k] <= side_d[k];
      end
      prod_q[0] <= 32'(side_q[0].ax) * 32'(side_q[0].bx);
      prod_q[1] <= 32'(side_q[0].ay) * 32'(side_q[0].by);
      prod_q[2] <= 32'(side_q[0].az) * 32'(side_q[0].bz);
      dd_q      <= dd_w[60:0];
      sq_v_q[0] <= (62'd1 << 60) - 62'(dd_q);
      sq_r_q[0] <= '0;
      if (dv_w < 0) begin
        vx_q[0] <= s_w;
        vy_q[0] <= -dv_w;
        vz_q[0] <= HalfPi;
      end else begin
        vx_q[0] <= dv_w;
        vy_q[0] <= s_w;
        vz_q[0] <= '0;
      end
      om_q <= vz_q[CordicSteps];
      ua_q <= signed'({1'b0, pua[48:16]});
      ub_q <= signed'({1'b0, pub[48:16]});
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    logic [61:0] bitk, trial;
    assign bitk  = 62'd1 << (60 - 2 * k);
    assign trial = sq_r_q[k] + bitk;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sq_v_q[k] >= trial) begin
          sq_v_q[k+1] <= sq_v_q[k] - trial;
          sq_r_q[k+1] <= (sq_r_q[k] >> 1) + bitk;
        end else begin
          sq_v_q[k+1] <= sq_v_q[k];
          sq_r_q[k+1] <= sq_r_q[k] >> 1;
        end
      end
    end
  end

  // arccosine as the angle of (d, s)
  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    logic signed [33:0] dx, dy;
    assign dx = vy_q[i] >>> i;
    assign dy = vx_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (vy_q[i] > 0) begin
          vx_q[i+1] <= vx_q[i] + dx;
          vy_q[i+1] <= vy_q[i] - dy;
          vz_q[i+1] <= vz_q[i] + atan_q30(i);
        end else begin
          vx_q[i+1] <= vx_q[i] - dx;
          vy_q[i+1] <= vy_q[i] + dy;
          vz_q[i+1] <= vz_q[i] - atan_q30(i);
        end
      end
    end
  end

  vs_sin u_sin_den (.clk_i(clk_i), .en_i(en), .theta_i(om_q), .sin_o(den_w));
  vs_sin u_sin_a   (.clk_i(clk_i), .en_i(en), .theta_i(ua_q), .sin_o(na_w));
  vs_sin u_sin_b   (.clk_i(clk_i), .en_i(en), .theta_i(ub_q), .sin_o(nb_w));

  vs_div u_div_a (.clk_i(clk_i), .en_i(en), .num_i(na_w), .den_i(den_w), .w_o(wa_w));
  vs_div u_div_b (.clk_i(clk_i), .en_i(en), .num_i(nb_w), .den_i(den_w), .w_o(wb_w));

  // weighted sum
  logic signed [63:0] pa_q [3];
  logic signed [63:0] pb_q [3];
  logic signed [63:0] sum  [3];
  logic signed [63:0] rnd  [3];
  logic signed [15:0] res  [3];
  logic signed [15:0] a_m  [3];
  logic signed [15:0] out_q [3];
  logic               degen_q;

  assign a_m[0] = side_q[IdxMul].ax;
  assign a_m[1] = side_q[IdxMul].ay;
  assign a_m[2] = side_q[IdxMul].az;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = pa_q[j] + pb_q[j] + (64'sd1 <<< 29);
      rnd[j] = sum[j] >>> 30;
      if (side_q[IdxMul].degen) res[j] = a_m[j];
      else if (rnd[j] > 64'sd32767) res[j] = 16'sh7fff;
      else if (rnd[j] < -64'sd32768) res[j] = -16'sh8000;
      else res[j] = rnd[j][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q[0] <= 64'(wa_w) * 64'(side_q[IdxMul-1].ax);
      pa_q[1] <= 64'(wa_w) * 64'(side_q[IdxMul-1].ay);
      pa_q[2] <= 64'(wa_w) * 64'(side_q[IdxMul-1].az);
      pb_q[0] <= 64'(wb_w) * 64'(side_q[IdxMul-1].bx);
      pb_q[1] <= 64'(wb_w) * 64'(side_q[IdxMul-1].by);
      pb_q[2] <= 64'(wb_w) * 64'(side_q[IdxMul-1].bz);
      for (int j = 0; j < 3; j++) begin
        out_q[j] <= res[j];
      end
      degen_q <= side_q[IdxMul].degen;
    end
  end

  assign out_m.out_x      = out_q[0];
  assign out_m.out_y      = out_q[1];
  assign out_m.out_z      = out_q[2];
  assign out_m.degenerate = degen_q;

endmodule

// ===== rtl/vs_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vs_check: port-level checks for vector_slerp
// Stall behavior of the two channels and the state after reset.
// ----------------------------------------------------------------------------
module vs_check (
  input logic   clk_i,
  input logic   rst_ni,
  vs_in_if.sink in_s,
  vs_out_if.source out_m
);

  // a result that waits holds its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |=> out_m.valid && $stable(out_m.out_x) &&
    $stable(out_m.out_y) && $stable(out_m.out_z) && $stable(out_m.degenerate))
    else $error("output beat changed while stalled");

  // a stalled output freezes the pipeline, so no input is taken
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && !out_m.ready |-> !in_s.ready)
    else $error("input accepted while output stalled");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_m.valid)
    else $error("output valid right after reset");

endmodule

bind vector_slerp vs_check u_vs_check (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_s  (in_s),
  .out_m (out_m)
);
